[design/rhls_pkg.sv]
// Shared types, constants and helper functions for the response header
// length scanner. No dependencies; every other design file imports this package.
package rhls_pkg;

   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int KEY_LEN = 14;

   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

   localparam logic [7:0] KEY_LENGTH [KEY_LEN] = '{
      8'h63, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
      8'h6C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68
   };
   localparam logic [7:0] KEY_OFFSET [KEY_LEN] = '{
      8'h63, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
      8'h6F, 8'h66, 8'h66, 8'h73, 8'h65, 8'h74
   };

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } rhls_req_type;

   typedef struct packed {
      logic               body_found;
      logic [15:0]        body_start;
      logic [15:0]        body_size;
      logic signed [31:0] slice_length;
      logic signed [31:0] slice_offset;
   } rhls_rsp_type;

   // Scanner state as it stands after the last byte of a record.
   typedef struct packed {
      logic        found;
      logic [31:0] start_pos;
      logic [31:0] record_len;
      logic [31:0] length_value;
      logic [31:0] offset_value;
   } rhls_snap_type;

   function automatic logic is_digit(input logic [7:0] ch);
      return (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
   endfunction

   // Upper-case letters fold to lower case; lower-case letters, digits and '-' pass; anything else folds to zero.
   function automatic logic [7:0] fold_char(input logic [7:0] ch);
      logic [7:0] r;
      r = 8'h00;
      if ((ch >= CHAR_UPPER_A) && (ch <= CHAR_UPPER_Z)) begin
         r = ch + 8'd32;
      end else if ((ch >= CHAR_LOWER_A) && (ch <= CHAR_LOWER_Z)) begin
         r = ch;
      end else if (is_digit(ch) || (ch == CHAR_MINUS)) begin
         r = ch;
      end
      return r;
   endfunction

endpackage

[design/response_header_length_scanner.sv]
// Response header length scanner. Takes one record byte per cycle and, after
// the byte flagged last, returns one transaction with the body start, body
// size and the content-length/content-offset slice. Throughput is one byte
// per clock; each byte is registered at the input and scanned from that
// register, and a result appears in the cycle after its last byte is scanned.
// The scan holds the decimal multiply-by-ten accumulate and, on the last byte,
// the 34-bit range check. The input stalls only while a finished result is
// still held by a stalled output and the next last byte is waiting.
// Depends on rhls_pkg, rhls_scan and rhls_result.
module response_header_length_scanner
   import rhls_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  rhls_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rhls_rsp_type rsp_data
);

   logic          in_valid_ff;
   rhls_req_type  in_data_ff;
   logic          out_valid_ff;
   rhls_rsp_type  rsp_ff;
   rhls_rsp_type  rsp_in;
   rhls_snap_type snap;
   logic          consume;

   // A non-final byte never produces a transaction, so only a final byte
   // waits on the output register.
   assign consume   = in_valid_ff && !(in_data_ff.last_byte && out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !consume;

   rhls_scan #(
      .POSITION_BITS(POSITION_BITS)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .item_en (consume),
      .ch      (in_data_ff.data_byte),
      .last    (in_data_ff.last_byte),
      .snap    (snap)
   );

   rhls_result u_result (
      .snap (snap),
      .rsp  (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (consume && in_data_ff.last_byte) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_data_ff <= req_data;
      end
      if (consume && in_data_ff.last_byte) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (consume && in_data_ff.last_byte) |=> rsp_valid)
      else $error("final byte taken without a result transaction");

   a_no_body_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.body_found)
         |-> (rsp_data.body_start == 16'd0) && (rsp_data.body_size == 16'd0))
      else $error("body position reported without a body");

   a_back_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.slice_offset[31] && (rsp_data.slice_length != 32'sd0))
         |-> ((34'(rsp_data.slice_length) + 34'(rsp_data.slice_offset)) <= 34'sd0))
      else $error("slice length passed range check past the body end");

endmodule

[design/rhls_scan.sv]
// Per-byte header scanner: line phase, name match, decimal value parser and
// byte position counter. Depends on rhls_pkg.
module rhls_scan
   import rhls_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          item_en,
   input  logic [7:0]    ch,
   input  logic          last,
   output rhls_snap_type snap
);

   typedef enum logic [2:0] {
      PH_LINE_START, PH_NAME, PH_VALUE_READY, PH_VALUE, PH_BODY_WAIT, PH_BODY_DONE
   } phase_type;

   typedef enum logic [1:0] {
      NUM_SKIP, NUM_SIGNED, NUM_DIGITS, NUM_DONE
   } num_type;

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
   localparam logic [31:0] LIMIT_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] LIMIT_NEG = 32'h8000_0000;

   phase_type phase_ff, phase_in;
   num_type   num_ff, num_in;
   logic [3:0]  name_cnt_ff, name_cnt_in;
   logic        len_match_ff, len_match_in;
   logic        off_match_ff, off_match_in;
   logic        value_seen_ff, value_seen_in;
   logic        negative_ff, negative_in;
   logic [31:0] accum_ff, accum_in;
   logic [31:0] length_ff, length_in;
   logic [31:0] offset_ff, offset_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic        found_ff, found_in;

   logic [7:0]  folded;
   logic        do_start, do_append, do_feed, do_finish;
   logic [3:0]  cnt_base;
   logic [35:0] prod;
   logic [31:0] limit;
   logic [31:0] digit_value;
   logic [31:0] line_value;

   assign folded = fold_char(ch);

   // Multiply-by-ten accumulate, saturated to the magnitude limit of the sign.
   always_comb begin
      prod  = ({4'b0, accum_ff} << 3) + ({4'b0, accum_ff} << 1) + 36'(ch - CHAR_ZERO);
      limit = negative_ff ? LIMIT_NEG : LIMIT_POS;
      digit_value = (prod > {4'b0, limit}) ? limit : prod[31:0];
      line_value  = negative_ff ? (32'd0 - accum_ff) : accum_ff;
   end

   always_comb begin
      phase_in      = phase_ff;
      num_in        = num_ff;
      name_cnt_in   = name_cnt_ff;
      len_match_in  = len_match_ff;
      off_match_in  = off_match_ff;
      value_seen_in = value_seen_ff;
      negative_in   = negative_ff;
      accum_in      = accum_ff;
      length_in     = length_ff;
      offset_in     = offset_ff;
      start_in      = start_ff;
      found_in      = found_ff;
      do_start      = 1'b0;
      do_append     = 1'b0;
      do_feed       = 1'b0;
      do_finish     = 1'b0;

      if (ch != CHAR_CR) begin
         case (phase_ff)
            PH_LINE_START: begin
               if (ch == CHAR_LF) begin
                  phase_in = PH_BODY_WAIT;
               end else begin
                  phase_in  = PH_NAME;
                  do_start  = 1'b1;
                  do_append = (folded != 8'h00);
               end
            end
            PH_NAME: begin
               if (folded != 8'h00) begin
                  do_append = 1'b1;
               end else if (ch == CHAR_LF) begin
                  do_finish = 1'b1;
               end else if (ch == CHAR_COLON) begin
                  phase_in = PH_VALUE_READY;
               end
            end
            PH_VALUE_READY: begin
               if (ch == CHAR_LF) begin
                  do_finish = 1'b1;
               end else if (ch != CHAR_SPACE) begin
                  phase_in = PH_VALUE;
                  do_feed  = 1'b1;
               end
            end
            PH_VALUE: begin
               if (ch == CHAR_LF) begin
                  do_finish = 1'b1;
               end else begin
                  do_feed = 1'b1;
               end
            end
            PH_BODY_WAIT: begin
               start_in = pos_ff;
               found_in = 1'b1;
               phase_in = PH_BODY_DONE;
            end
            default: begin
            end
         endcase
      end

      if (do_start) begin
         name_cnt_in   = 4'd0;
         len_match_in  = 1'b1;
         off_match_in  = 1'b1;
         value_seen_in = 1'b0;
         num_in        = NUM_SKIP;
         negative_in   = 1'b0;
         accum_in      = 32'd0;
      end

      cnt_base = do_start ? 4'd0 : name_cnt_ff;
      if (do_append) begin
         if (cnt_base < 4'(KEY_LEN)) begin
            if (KEY_LENGTH[cnt_base] != folded) len_match_in = 1'b0;
            if (KEY_OFFSET[cnt_base] != folded) off_match_in = 1'b0;
         end
         if (cnt_base != 4'hF) name_cnt_in = cnt_base + 4'd1;
      end

      if (do_feed) begin
         value_seen_in = 1'b1;
         case (num_ff)
            NUM_SKIP: begin
               if ((ch == CHAR_SPACE) || (ch == CHAR_TAB) || (ch == CHAR_VT)
                   || (ch == CHAR_FF)) begin
                  num_in = NUM_SKIP;
               end else if (ch == CHAR_PLUS) begin
                  num_in = NUM_SIGNED;
               end else if (ch == CHAR_MINUS) begin
                  negative_in = 1'b1;
                  num_in      = NUM_SIGNED;
               end else if (is_digit(ch)) begin
                  accum_in = digit_value;
                  num_in   = NUM_DIGITS;
               end else begin
                  num_in = NUM_DONE;
               end
            end
            NUM_SIGNED, NUM_DIGITS: begin
               if (is_digit(ch)) begin
                  accum_in = digit_value;
                  num_in   = NUM_DIGITS;
               end else begin
                  num_in = NUM_DONE;
               end
            end
            default: begin
            end
         endcase
      end

      if (do_finish) begin
         phase_in = PH_LINE_START;
         if ((name_cnt_ff == 4'(KEY_LEN)) && value_seen_ff) begin
            if (len_match_ff) begin
               length_in = line_value;
            end else if (off_match_ff) begin
               offset_in = line_value;
            end
         end
      end

      // Position saturates, so the next value is also the saturated record length.
      pos_in = (pos_ff != POS_MAX) ? pos_ff + 1'b1 : pos_ff;
   end

   always_comb begin
      snap.found        = found_in;
      snap.start_pos    = 32'(start_in);
      snap.record_len   = 32'(pos_in);
      snap.length_value = length_in;
      snap.offset_value = offset_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (item_en && last)) begin
         phase_ff      <= PH_LINE_START;
         num_ff        <= NUM_SKIP;
         name_cnt_ff   <= 4'd0;
         len_match_ff  <= 1'b1;
         off_match_ff  <= 1'b1;
         value_seen_ff <= 1'b0;
         negative_ff   <= 1'b0;
         accum_ff      <= 32'd0;
         length_ff     <= 32'd0;
         offset_ff     <= 32'd0;
         pos_ff        <= '0;
         start_ff      <= '0;
         found_ff      <= 1'b0;
      end else if (item_en) begin
         phase_ff      <= phase_in;
         num_ff        <= num_in;
         name_cnt_ff   <= name_cnt_in;
         len_match_ff  <= len_match_in;
         off_match_ff  <= off_match_in;
         value_seen_ff <= value_seen_in;
         negative_ff   <= negative_in;
         accum_ff      <= accum_in;
         length_ff     <= length_in;
         offset_ff     <= offset_in;
         pos_ff        <= pos_in;
         start_ff      <= start_in;
         found_ff      <= found_in;
      end
   end

endmodule

[design/rhls_result.sv]
// Builds the result transaction from the end-of-record scanner state:
// body size and the slice range check. Depends on rhls_pkg.
module rhls_result
   import rhls_pkg::*;
(
   input  rhls_snap_type snap,
   output rhls_rsp_type  rsp
);

   logic [31:0]        start;
   logic [31:0]        size;
   logic signed [31:0] slen;
   logic signed [31:0] soff;
   logic signed [33:0] sum;
   logic signed [33:0] size_ext;

   always_comb begin
      start = snap.found ? snap.start_pos : 32'd0;
      size  = 32'd0;
      if (snap.found && (snap.record_len >= snap.start_pos)) begin
         size = snap.record_len - snap.start_pos;
      end

      slen     = $signed(snap.length_value);
      soff     = $signed(snap.offset_value);
      sum      = 34'(slen) + 34'(soff);
      size_ext = $signed({2'b00, size});

      rsp.body_found   = snap.found;
      rsp.body_start   = start[15:0];
      rsp.body_size    = size[15:0];
      rsp.slice_offset = soff;
      rsp.slice_length = slen;
      // A negative offset counts back from the body end, so length plus
      // offset must not reach past it; a positive one must fit in the body.
      if ((soff < 0) && (sum > 34'sd0)) begin
         rsp.slice_length = 32'sd0;
      end else if ((soff > 0) && (sum > size_ext)) begin
         rsp.slice_length = 32'sd0;
      end
   end

endmodule
